FILE: rtl/core/ipv6_text_address_parser_top_assert.svh
// Assertion macros for the IPv6 text address parser.
// Included by the top level; depends on nothing else.
`ifndef IPV6_TEXT_ADDRESS_PARSER_TOP_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication under the given clock and active-low reset.
`define IPV6TP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ipv6 parser assertion failed");
// Next-cycle implication under the given clock and active-low reset.
`define IPV6TP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ipv6 parser assertion failed");
`else
`define IPV6TP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IPV6TP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/ipv6tp_pkg.sv
// Package for the IPv6 text address parser: word types, item class codes
// and sizing constants. Used by every module of the block.
`default_nettype none
package ipv6tp_pkg;

	localparam int GROUP_COUNT = 8;
	localparam int HALF_GROUPS = 4;
	localparam int GROUP_W = 16;
	localparam int MAX_DIGITS = 4;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} ipv6tp_text_word_t;

	typedef struct packed {
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic        parse_error;
	} ipv6tp_addr_word_t;

	typedef enum logic [1:0] {
		CLS_HEX   = 2'd0,
		CLS_COLON = 2'd1,
		CLS_OTHER = 2'd2
	} ipv6tp_class_t;

	typedef struct packed {
		ipv6tp_class_t cls;
		logic [3:0]    nibble;
		logic          last;
	} ipv6tp_item_t;

	typedef struct packed {
		logic take;
		logic fin_hold;
	} ipv6tp_back_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/ipv6_text_address_parser_top.sv
// IPv6 text address parser, top level: front end, queue and back end.
// Depends on ipv6tp_pkg and ipv6_text_address_parser_top_assert.svh.
//
// The text channel (text_valid, text_stall, text_word) carries one ASCII
// character per word, with is_last set on the final character of an address.
// The address channel (addr_valid, addr_stall, addr_word) carries one word per
// address: the 128-bit value split into addr_high (group 0 on top) and
// addr_low (group 7 at the bottom), and parse_error, with a zero address on
// error. Characters not marked last produce no word.
// Throughput is one character per cycle while text_stall is low. The last
// character of an address passes from the queue into the finish registers
// (fin_valid_s2, group counts and error flag), then through address
// assembly into the output register. The parse registers handle one
// character per cycle unless the back end pauses, so they set the rate.
// When the receiver stalls, the finished address waits in the output register
// and the next address may still be assembled behind it; once that one is
// ready too, the back end pauses, the queue fills, and text_stall rises.
// Reset clears the queue, all parse state and the output valid; the block is
// ready for a new address straight out of reset.
`default_nettype none
`include "ipv6_text_address_parser_top_assert.svh"
module ipv6_text_address_parser_top import ipv6tp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire ipv6tp_text_word_t text_word,
	input  wire                    text_valid,
	output logic                   text_stall,
	output ipv6tp_addr_word_t      addr_word,
	output logic                   addr_valid,
	input  wire                    addr_stall
);

	logic                q_full, q_push, q_valid;
	ipv6tp_item_t        front_item, q_head;
	ipv6tp_back_status_t back_status;

	ipv6tp_front u_front (
		.text_word  (text_word),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.queue_full (q_full),
		.push       (q_push),
		.item       (front_item)
	);

	ipv6tp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (front_item),
		.pop        (back_status.take),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head)
	);

	ipv6tp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_head),
		.item_valid (q_valid),
		.status     (back_status),
		.addr_word  (addr_word),
		.addr_valid (addr_valid),
		.addr_stall (addr_stall)
	);

	// A rejected address never carries a partial value.
	`IPV6TP_ASSERT_IMPLY(a_error_zero_addr, clk, arst_n, addr_valid && addr_word.parse_error, addr_word.addr_high == 64'd0 && addr_word.addr_low == 64'd0)
	// An accepted character is in the queue in the next cycle.
	`IPV6TP_ASSERT_NEXT(a_queue_holds_char, clk, arst_n, text_valid && !text_stall, q_valid)
	// A held finished address means the output register is still occupied.
	`IPV6TP_ASSERT_NEXT(a_hold_keeps_output, clk, arst_n, back_status.fin_hold, addr_valid)

endmodule
`default_nettype wire

FILE: rtl/core/ipv6tp_front.sv
// Front end of the IPv6 parser: classifies each character and hands it to
// the queue. Depends on ipv6tp_pkg.
`default_nettype none
module ipv6tp_front import ipv6tp_pkg::*; (
	input  wire ipv6tp_text_word_t text_word,
	input  wire                    text_valid,
	output logic                   text_stall,
	input  wire                    queue_full,
	output logic                   push,
	output ipv6tp_item_t           item
);

	logic [7:0] c;

	assign c = text_word.char_code;
	assign text_stall = queue_full;
	assign push = text_valid && !queue_full;

	// Decimal digits carry their value in the low nibble; both letter cases
	// of a to f sit at low nibble 1 to 6, so adding nine gives 10 to 15.
	always_comb begin
		item.last = text_word.is_last;
		item.nibble = c[3:0];
		item.cls = CLS_OTHER;
		if (c >= 8'h30 && c <= 8'h39) begin
			item.cls = CLS_HEX;
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			item.cls = CLS_HEX;
			item.nibble = c[3:0] + 4'd9;
		end else if (c == CHAR_COLON) begin
			item.cls = CLS_COLON;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ipv6tp_queue.sv
// Short FIFO between the classifying front end and the parsing back end.
// Depends on ipv6tp_pkg for the item type.
`default_nettype none
module ipv6tp_queue import ipv6tp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire          ipv6tp_item_t push_item,
	input  wire          pop,
	output logic         full,
	output logic         head_valid,
	output ipv6tp_item_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ipv6tp_item_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ipv6tp_back.sv
// Back end of the IPv6 parser: group and colon rules, group stores, address
// assembly and the output register. Depends on ipv6tp_pkg.
`default_nettype none
module ipv6tp_back import ipv6tp_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire ipv6tp_item_t   item,
	input  wire                 item_valid,
	output ipv6tp_back_status_t status,
	output ipv6tp_addr_word_t   addr_word,
	output logic                addr_valid,
	input  wire                 addr_stall
);

	logic [GROUP_W-1:0] left_q [GROUP_COUNT];
	logic [GROUP_W-1:0] right_q [GROUP_COUNT];
	logic [3:0]  lc_q, rc_q;
	logic [15:0] acc_q;
	logic [2:0]  dcnt_q;
	logic        dc_q, pc_q, lcp_q, err_q;

	logic        fin_valid_s2;
	logic [3:0]  fin_lc_s2, fin_rc_s2;
	logic        fin_err_s2;

	logic              out_valid_q;
	ipv6tp_addr_word_t out_word_q;

	logic        out_free, fin_hold, take;
	logic [15:0] acc_a;
	logic [2:0]  dcnt_a;
	logic        dc_a, pc_a, lcp_a, err_a, err_c;
	logic        push_c, push_f, push, overflow, push_ok, err_b, err_final, count_bad;
	logic [3:0]  lc_n, rc_n;
	logic [4:0]  total_n;
	logic [GROUP_W-1:0] groups [GROUP_COUNT];
	ipv6tp_addr_word_t  built;

	assign out_free = !out_valid_q || !addr_stall;
	assign fin_hold = fin_valid_s2 && !out_free;
	assign take = item_valid && !fin_hold;
	assign status.take = take;
	assign status.fin_hold = fin_hold;
	assign addr_valid = out_valid_q;
	assign addr_word = out_word_q;

	// Effect of one character on the parse state.
	always_comb begin
		acc_a = acc_q;
		dcnt_a = dcnt_q;
		dc_a = dc_q;
		pc_a = pc_q;
		lcp_a = lcp_q;
		err_a = err_q;
		push_c = 1'b0;
		if (!err_q) begin
			case (item.cls)
				CLS_HEX: begin
					if (lcp_q || dcnt_q >= 3'(MAX_DIGITS)) begin
						err_a = 1'b1;
					end else begin
						acc_a = {acc_q[11:0], item.nibble};
						dcnt_a = dcnt_q + 3'd1;
						pc_a = 1'b0;
					end
				end
				CLS_COLON: begin
					pc_a = 1'b1;
					if (pc_q) begin
						if (dc_q) begin
							err_a = 1'b1;
						end else begin
							dc_a = 1'b1;
							lcp_a = 1'b0;
						end
					end else if (dcnt_q == 3'd0) begin
						lcp_a = 1'b1;
					end else begin
						push_c = 1'b1;
					end
				end
				default: begin
					err_a = 1'b1;
				end
			endcase
		end
	end

	// End-of-text checks, the group push and the group count rule. A final
	// colon that closes a group is a lone trailing colon, even after a
	// double colon.
	always_comb begin
		push_f = 1'b0;
		err_c = 1'b0;
		if (item.last && !err_a) begin
			if (pc_a) begin
				err_c = !dc_a || (rc_q != 4'd0) || push_c;
			end else if (dcnt_a != 3'd0) begin
				push_f = 1'b1;
			end else begin
				err_c = 1'b1;
			end
		end
		push = push_c || push_f;
		overflow = ({1'b0, lc_q} + {1'b0, rc_q}) >= 5'(GROUP_COUNT);
		push_ok = push && !overflow;
		err_b = err_a || err_c || (push && overflow);
		lc_n = lc_q + 4'(push_ok && !dc_a);
		rc_n = rc_q + 4'(push_ok && dc_a);
		total_n = {1'b0, lc_n} + {1'b0, rc_n};
		count_bad = dc_a ? (total_n >= 5'(GROUP_COUNT)) : (total_n != 5'(GROUP_COUNT));
		err_final = err_b || count_bad;
	end

	// Groups before the double colon fill upward; groups after it shift in at
	// the bottom so they already sit at their final places.
	always_ff @(posedge clk) begin
		if (take && push_ok) begin
			if (dc_a) begin
				for (int j = 0; j < GROUP_COUNT - 1; j++) begin
					right_q[j] <= right_q[j+1];
				end
				right_q[GROUP_COUNT-1] <= acc_a;
			end else begin
				left_q[lc_q[2:0]] <= acc_a;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= '0;
			rc_q <= '0;
			acc_q <= '0;
			dcnt_q <= '0;
			dc_q <= 1'b0;
			pc_q <= 1'b0;
			lcp_q <= 1'b0;
			err_q <= 1'b0;
		end else if (take) begin
			if (item.last) begin
				lc_q <= '0;
				rc_q <= '0;
				acc_q <= '0;
				dcnt_q <= '0;
				dc_q <= 1'b0;
				pc_q <= 1'b0;
				lcp_q <= 1'b0;
				err_q <= 1'b0;
			end else begin
				lc_q <= lc_n;
				rc_q <= rc_n;
				acc_q <= push ? 16'd0 : acc_a;
				dcnt_q <= push ? 3'd0 : dcnt_a;
				dc_q <= dc_a;
				pc_q <= pc_a;
				lcp_q <= lcp_a;
				err_q <= err_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s2 <= 1'b0;
		end else if (take && item.last) begin
			fin_valid_s2 <= 1'b1;
		end else if (out_free) begin
			fin_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.last) begin
			fin_lc_s2 <= lc_n;
			fin_rc_s2 <= rc_n;
			fin_err_s2 <= err_final;
		end
	end

	always_comb begin
		for (int k = 0; k < GROUP_COUNT; k++) begin
			if (4'(k) < fin_lc_s2) begin
				groups[k] = left_q[k];
			end else if ((5'(k) + {1'b0, fin_rc_s2}) >= 5'(GROUP_COUNT)) begin
				groups[k] = right_q[k];
			end else begin
				groups[k] = '0;
			end
		end
		built.addr_high = '0;
		built.addr_low = '0;
		built.parse_error = fin_err_s2;
		if (!fin_err_s2) begin
			for (int k = 0; k < HALF_GROUPS; k++) begin
				built.addr_high[(HALF_GROUPS-1-k)*GROUP_W +: GROUP_W] = groups[k];
				built.addr_low[(HALF_GROUPS-1-k)*GROUP_W +: GROUP_W] = groups[k+HALF_GROUPS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fin_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fin_valid_s2) begin
			out_word_q <= built;
		end
	end

endmodule
`default_nettype wire
